>>> hdl/deq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the double-ended queue.
// Used by the storage cells, the cell chain and the top level.
package deq_pkg;

  // Widths of the stream fields.
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned IN_W     = 40;
  localparam int unsigned OUT_W    = 72;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 2'd2;

  // Value shown at both ends of an empty queue.
  localparam logic [VAL_W-1:0] EMPTY_READ = '1;

  // What every cell of a chain does at each clock edge.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT_UP,    // take the neighbor nearer the head (head takes new data)
    CELL_SHIFT_DOWN,  // take the neighbor farther from the head
    CELL_WRITE_AT     // the cell whose index equals the count takes new data
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [VAL_W-1:0]  data;
  } cell_ctrl_t;

endpackage

>>> hdl/deq_cell.sv
`timescale 1ns / 1ps
// One storage cell of a queue chain: a 32-bit entry and its update mux.
// Depends on deq_pkg for the cell control struct.
module deq_cell import deq_pkg::*; #(
  parameter int unsigned CW  = 5,
  parameter int unsigned IDX = 0
) (
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [CW-1:0]    count,
  input  logic [VAL_W-1:0] low_val,
  input  logic [VAL_W-1:0] high_val,
  output logic [VAL_W-1:0] value
);

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  // Entry update: shift with a neighbor or load at the fill position.
  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_SHIFT_UP: begin
        value <= low_val;
      end
      CELL_SHIFT_DOWN: begin
        value <= high_val;
      end
      CELL_WRITE_AT: begin
        if (count == MY_IDX) begin
          value <= ctrl.data;
        end
      end
      default: begin
        value <= value;
      end
    endcase
  end

endmodule

>>> hdl/deq_chain.sv
`timescale 1ns / 1ps
// A row of DEPTH storage cells that shift toward or away from the head.
// Depends on deq_pkg and deq_cell.
module deq_chain import deq_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned CW    = 5
) (
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [CW-1:0]    count,
  output logic [VAL_W-1:0] head_value
);

  logic [VAL_W-1:0] cell_val [DEPTH];

  // Each cell sees its two neighbors; the head takes new data from below
  // and the last cell sees itself from above.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] low_in;
    logic [VAL_W-1:0] high_in;

    if (i == 0) begin : g_head
      assign low_in = ctrl.data;
    end else begin : g_mid_low
      assign low_in = cell_val[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign high_in = cell_val[i];
    end else begin : g_mid_high
      assign high_in = cell_val[i+1];
    end

    deq_cell #(
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .count    (count),
      .low_val  (low_in),
      .high_val (high_in),
      .value    (cell_val[i])
    );
  end

  assign head_value = cell_val[0];

endmodule

>>> hdl/double_ended_queue_top.sv
`timescale 1ns / 1ps
// Top level of the double-ended queue: command decode, count and result beat.
// Depends on deq_pkg and deq_chain.
//
//   Channel | Direction | Beat contents
//   s_*     | in        | command, data_value
//   m_*     | out       | front_value, back_value, entry_count, is_empty, status
//
// One command is taken per cycle while no result beat waits on m_tready; its result beat appears the cycle after.
// Two chains of DEPTH cells hold the contents, one with the front at cell 0
// and one with the back at cell 0, so each end is read from a fixed cell.
// Reset empties the queue at once; stored entries need no clearing.
// A result beat waits in the output register while m_tready is low, and a
// new command is taken in the same cycle the waiting beat leaves.
module double_ended_queue_top import deq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // [2:0] command, [34:3] data_value, rest zero
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // [31:0] front_value, [63:32] back_value,
                                      // [68:64] entry_count, [69] is_empty,
                                      // [71:70] status
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic [STATUS_W-1:0] status;
  logic [STATUS_W-1:0] status_next;
  logic                accept;
  logic [CMD_W-1:0]    cmd;
  logic [VAL_W-1:0]    push_val;
  cell_ctrl_t          front_ctrl;
  cell_ctrl_t          back_ctrl;
  logic [VAL_W-1:0]    front_head;
  logic [VAL_W-1:0]    back_head;
  logic                empty;
  logic                full;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign cmd      = s_tdata[CMD_W-1:0];
  assign push_val = s_tdata[CMD_W+VAL_W-1:CMD_W];
  assign empty    = (count == '0);
  assign full     = (count == FULL_COUNT);

  // Command decode into chain operations, count and status.
  always_comb begin
    front_ctrl.op   = CELL_HOLD;
    front_ctrl.data = push_val;
    back_ctrl.op    = CELL_HOLD;
    back_ctrl.data  = push_val;
    count_next      = count;
    status_next     = status;
    if (accept) begin
      status_next = ST_OK;
      case (cmd)
        CMD_PUSH_BACK: begin
          if (full) begin
            status_next = ST_PUSH_FULL;
          end else begin
            front_ctrl.op = CELL_WRITE_AT;
            back_ctrl.op  = CELL_SHIFT_UP;
            count_next    = count + 1'b1;
          end
        end
        CMD_PUSH_FRONT: begin
          if (full) begin
            status_next = ST_PUSH_FULL;
          end else begin
            front_ctrl.op = CELL_SHIFT_UP;
            back_ctrl.op  = CELL_WRITE_AT;
            count_next    = count + 1'b1;
          end
        end
        CMD_POP_FRONT: begin
          if (empty) begin
            status_next = ST_POP_EMPTY;
          end else begin
            front_ctrl.op = CELL_SHIFT_DOWN;
            count_next    = count - 1'b1;
          end
        end
        CMD_POP_BACK: begin
          if (empty) begin
            status_next = ST_POP_EMPTY;
          end else begin
            back_ctrl.op = CELL_SHIFT_DOWN;
            count_next   = count - 1'b1;
          end
        end
        default: begin
          // Query and unused codes leave the queue as it is.
          status_next = ST_OK;
        end
      endcase
    end
  end

  // Chain with the front entry at cell 0.
  deq_chain #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_front_chain (
    .clk        (clk),
    .ctrl       (front_ctrl),
    .count      (count),
    .head_value (front_head)
  );

  // Chain with the back entry at cell 0.
  deq_chain #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_back_chain (
    .clk        (clk),
    .ctrl       (back_ctrl),
    .count      (count),
    .head_value (back_head)
  );

  // Count, status and output beat valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      status   <= ST_OK;
      m_tvalid <= 1'b0;
    end else begin
      count  <= count_next;
      status <= status_next;
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result beat is read straight from the state left by the last command.
  assign m_tdata = {status,
                    empty,
                    COUNT_W'(count),
                    (empty ? EMPTY_READ : back_head),
                    (empty ? EMPTY_READ : front_head)};

endmodule
